// ===== rtl/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared widths, types and digit helpers of the Luhn card number classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

	// binary card number and its decimal image
	localparam int BIN_W      = 54;
	localparam int DIGITS     = 17;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int BIT_CNT_W  = $clog2(BIN_W);
	localparam int DIG_IDX_W  = $clog2(DIGITS + 1);

	// issuer codes
	localparam logic [1:0] ISSUER_NONE = 2'd0;
	localparam logic [1:0] ISSUER_A    = 2'd1;
	localparam logic [1:0] ISSUER_B    = 2'd2;
	localparam logic [1:0] ISSUER_C    = 2'd3;

	// summary of the digit scan, handed to the classifier
	typedef struct packed {
		logic       total_zero;
		logic [4:0] count;
		logic [6:0] lead;
	} luhn_scan_t;

	// doubled digit with its two decimal digits added
	function automatic logic [3:0] luhn_double(input logic [3:0] d);
		logic [4:0] d2;
		d2 = {d, 1'b0};
		if (d2 >= 5'd10) begin
			d2 = d2 - 5'd9;
		end
		return d2[3:0];
	endfunction

	// add 3 to a bcd digit of 5 or more before the next shift
	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

endpackage

// ===== rtl/luhn_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// luhn_bcd_conv
// Bit-serial binary to decimal converter: one shift-and-adjust per cycle.
// ----------------------------------------------------------------------------
module luhn_bcd_conv
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] bin,
	output logic             done,
	output logic [BCD_W-1:0] bcd
);

	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [BCD_W-1:0]     adj;

	// adjust every digit independently
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = bcd_adjust(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_CNT_W'(BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== rtl/luhn_digit_scan.sv =====
// ----------------------------------------------------------------------------
// luhn_digit_scan
// Walks the decimal digits from the right, one per cycle: Luhn total mod 10,
// digit count and leading pair.
// ----------------------------------------------------------------------------
module luhn_digit_scan
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BCD_W-1:0] bcd,
	output logic             done,
	output luhn_scan_t       scan
);

	logic [BCD_W-1:0]     dig_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic                 busy_q;
	logic                 done_q;
	logic [3:0]           total_q;
	logic [4:0]           count_q;
	logic [6:0]           lead_q;
	logic [3:0]           prev_q;

	logic [3:0] d;
	logic [3:0] v;
	logic [4:0] sum;

	always_comb begin
		d   = dig_q[3:0];
		v   = idx_q[0] ? luhn_double(d) : d;
		sum = {1'b0, total_q} + {1'b0, v};
		if (sum >= 5'd10) begin
			sum = sum - 5'd10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == DIG_IDX_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dig_q   <= bcd;
			total_q <= '0;
			count_q <= '0;
			lead_q  <= '0;
			prev_q  <= '0;
		end else if (busy_q) begin
			dig_q   <= {4'd0, dig_q[BCD_W-1:4]};
			total_q <= sum[3:0];
			prev_q  <= d;
			if (d != 4'd0) begin
				count_q <= 5'(idx_q) + 5'd1;
				if (idx_q == '0) begin
					lead_q <= {3'd0, d};
				end else begin
					lead_q <= 7'({3'd0, d} * 7'd10) + {3'd0, prev_q};
				end
			end
		end
	end

	assign done            = done_q;
	assign scan.total_zero = (total_q == 4'd0);
	assign scan.count      = count_q;
	assign scan.lead       = lead_q;

endmodule

// ===== rtl/luhn_card_number_classifier.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_classifier
// Luhn mod-10 check and issuer classification of a binary card number.
// ----------------------------------------------------------------------------
// a transfer in happens when start is high while busy is low; busy then stays
// high until the result is out, and one item is handled at a time. each item
// passes from start to the done strobe through the bit-serial binary to
// decimal converter (one input bit per cycle), the digit scan (one decimal
// digit per cycle) and the hand-off and classification. the result shows on
// issuer, checksum_ok, digit_count and leading_pair, marked by done, which is
// high for exactly one cycle; the receiver cannot stall it, so it must take
// every result transfer as it comes. a new start is taken already in the
// cycle in which done is shown.
module luhn_card_number_classifier
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [BIN_W-1:0] card_number,
	output logic             done,
	output logic [1:0]       issuer,
	output logic             checksum_ok,
	output logic [4:0]       digit_count,
	output logic [6:0]       leading_pair
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]       state_q;
	logic             accept;
	logic             conv_done;
	logic [BCD_W-1:0] bcd;
	logic             scan_done;
	luhn_scan_t       scan;
	logic [1:0]       issuer_d;

	logic             done_q;
	logic [1:0]       issuer_q;
	logic             ok_q;
	logic [4:0]       count_q;
	logic [6:0]       lead_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// binary to decimal, one bit per cycle
	luhn_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.bin    (card_number),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// digit walk from the least significant digit
	luhn_digit_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_done),
		.bcd    (bcd),
		.done   (scan_done),
		.scan   (scan)
	);

	// sequencer: idle, converting, scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// issuer rules; a zero input has no digits and never gets an issuer
	always_comb begin
		issuer_d = ISSUER_NONE;
		if (scan.total_zero && (scan.count != 5'd0)) begin
			if (scan.count == 5'd16) begin
				if (scan.lead >= 7'd40 && scan.lead <= 7'd49) begin
					issuer_d = ISSUER_A;
				end else if (scan.lead > 7'd50 && scan.lead < 7'd56) begin
					issuer_d = ISSUER_B;
				end
			end else if (scan.count == 5'd15) begin
				if (scan.lead == 7'd34 || scan.lead == 7'd37) begin
					issuer_d = ISSUER_C;
				end
			end else if (scan.count == 5'd13) begin
				if (scan.lead >= 7'd40 && scan.lead <= 7'd49) begin
					issuer_d = ISSUER_A;
				end
			end
		end
	end

	// one-cycle result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= scan_done;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (scan_done) begin
			issuer_q <= issuer_d;
			ok_q     <= scan.total_zero;
			count_q  <= scan.count;
			lead_q   <= scan.lead;
		end
	end

	assign done         = done_q;
	assign issuer       = issuer_q;
	assign checksum_ok  = ok_q;
	assign digit_count  = count_q;
	assign leading_pair = lead_q;

endmodule

// ===== sim/luhn_card_number_classifier_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_tb
// Self-checking bench: directed and random card numbers against a predictor.
// ----------------------------------------------------------------------------
// card numbers go in through the start/busy command transfer. each accepted
// number without a typed outcome goes through a predictor of the Luhn check
// and the issuer rules, and the outcome is queued. every done strobe pops the
// oldest outcome and compares it field by field. a short table of directed
// numbers comes first, then random numbers in three idle phases: sender idles
// rarely, sender idles often, sender never idles.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_tb
	import luhn_pkg::*;
();

	// one result transfer
	typedef struct packed {
		logic [1:0] issuer;
		logic       checksum_ok;
		logic [4:0] digit_count;
		logic [6:0] leading_pair;
	} card_result_t;

	// one row of the directed table; typed rows carry their outcome
	typedef struct packed {
		logic [BIN_W-1:0] number;
		logic             typed;
		card_result_t     res;
	} card_row_t;

	localparam card_result_t NO_RES = '{ISSUER_NONE, 1'b0, 5'd0, 7'd0};

	// extremes, every issuer with its neighbors, bad checksum, over-long input
	localparam card_row_t DIRECTED_ROWS [0:24] = '{
		// zero: no digits, total zero, still no issuer
		'{54'd0,                       1'b1, '{ISSUER_NONE, 1'b1, 5'd0,  7'd0}},
		// one digit: leading pair is the digit itself
		'{54'd1,                       1'b1, '{ISSUER_NONE, 1'b0, 5'd1,  7'd1}},
		'{54'd18,                      1'b1, '{ISSUER_NONE, 1'b1, 5'd2,  7'd18}},
		'{54'd1000_0000_0000_0000,     1'b1, '{ISSUER_NONE, 1'b0, 5'd16, 7'd10}},
		// seventeen digits
		'{54'd1_0000_0000_0000_0000,   1'b1, '{ISSUER_NONE, 1'b0, 5'd17, 7'd10}},
		'{54'd4111_1111_1111_1111,     1'b1, '{ISSUER_A,    1'b1, 5'd16, 7'd41}},
		// same number, broken checksum
		'{54'd4111_1111_1111_1112,     1'b0, NO_RES},
		// issuer b window edges, all with a good checksum
		'{54'd5100_0000_0000_0008,     1'b0, NO_RES},
		'{54'd5000_0000_0000_0009,     1'b0, NO_RES},
		'{54'd5500_0000_0000_0004,     1'b0, NO_RES},
		'{54'd5600_0000_0000_0003,     1'b0, NO_RES},
		// issuer a, sixteen digits, and a lead just below
		'{54'd4000_0000_0000_0002,     1'b0, NO_RES},
		'{54'd4900_0000_0000_0003,     1'b0, NO_RES},
		'{54'd3900_0000_0000_0005,     1'b0, NO_RES},
		// issuer c and a near miss
		'{54'd340_0000_0000_0009,      1'b0, NO_RES},
		'{54'd370_0000_0000_0002,      1'b0, NO_RES},
		'{54'd350_0000_0000_0006,      1'b0, NO_RES},
		// thirteen digits hit, fourteen digits miss, then a thirteen-digit miss and all nines
		'{54'd4_0000_0000_0006,        1'b0, NO_RES},
		'{54'd40_0000_0000_0002,       1'b0, NO_RES},
		'{54'd5_0000_0000_0005,        1'b0, NO_RES},
		'{54'd9999_9999_9999_9999,     1'b0, NO_RES},
		// all ones, top bit alone, both checkerboards
		'{54'h3F_FFFF_FFFF_FFFF,       1'b0, NO_RES},
		'{54'h20_0000_0000_0000,       1'b0, NO_RES},
		'{54'h2_AAAA_AAAA_AAAA_A,      1'b0, NO_RES},
		'{54'h1_5555_5555_5555_5,      1'b0, NO_RES}
	};

	localparam int RANDOM_PER_PHASE = 210;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             start        = 1'b0;
	logic [BIN_W-1:0] card_number  = '0;
	logic             busy;
	logic             done;
	logic [1:0]       issuer;
	logic             checksum_ok;
	logic [4:0]       digit_count;
	logic [6:0]       leading_pair;

	// outcomes of accepted numbers, oldest first
	card_result_t pending_results [$];
	int           fail_cnt = 0;

	luhn_card_number_classifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.card_number  (card_number),
		.done         (done),
		.issuer       (issuer),
		.checksum_ok  (checksum_ok),
		.digit_count  (digit_count),
		.leading_pair (leading_pair)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Luhn total: every second digit from the right doubled, product digits added
	function automatic int unsigned luhn_total(input longint unsigned value);
		longint unsigned rest;
		int unsigned     digit;
		int unsigned     total;
		bit              dbl;
		rest  = value;
		total = 0;
		dbl   = 1'b0;
		while (rest != 0) begin
			digit = int'(rest % 10);
			if (dbl) begin
				digit = digit * 2;
				if (digit >= 10) begin
					digit = digit - 9;
				end
			end
			total = total + digit;
			dbl   = !dbl;
			rest  = rest / 10;
		end
		return total;
	endfunction

	// expected classification of one card number
	function automatic card_result_t classify_card(input logic [BIN_W-1:0] number);
		longint unsigned rest;
		longint unsigned lead;
		int unsigned     count;
		card_result_t    r;
		rest  = number;
		lead  = number;
		count = 0;
		while (rest != 0) begin
			rest  = rest / 10;
			count = count + 1;
		end
		while (lead >= 100) begin
			lead = lead / 10;
		end
		r.checksum_ok  = (luhn_total(number) % 10) == 0;
		r.digit_count  = count[4:0];
		r.leading_pair = lead[6:0];
		r.issuer       = ISSUER_NONE;
		if (r.checksum_ok && number != 0) begin
			if (count == 16) begin
				if (lead / 10 == 4) begin
					r.issuer = ISSUER_A;
				end else if (lead > 50 && lead < 56) begin
					r.issuer = ISSUER_B;
				end
			end else if (count == 15) begin
				if (lead == 34 || lead == 37) begin
					r.issuer = ISSUER_C;
				end
			end else if (count == 13) begin
				if (lead / 10 == 4) begin
					r.issuer = ISSUER_A;
				end
			end
		end
		return r;
	endfunction

	// number with a given leading pair and length, random middle digits;
	// the last digit is chosen to make the checksum good when asked
	function automatic logic [BIN_W-1:0] build_card(input int unsigned lead,
			input int unsigned len, input bit make_valid);
		longint unsigned acc;
		acc = lead;
		for (int unsigned i = 2; i < len - 1; i++) begin
			acc = acc * 10 + $urandom_range(9);
		end
		acc = acc * 10;
		if (make_valid) begin
			acc = acc + (10 - luhn_total(acc) % 10) % 10;
		end else begin
			acc = acc + $urandom_range(9);
		end
		return acc[BIN_W-1:0];
	endfunction

	// random card number: mostly well-formed, the rest raw bit patterns
	function automatic logic [BIN_W-1:0] random_card();
		logic [63:0]  raw;
		int unsigned  lead;
		int unsigned  len;
		bit           make_valid;
		raw        = {$urandom, $urandom};
		make_valid = $urandom_range(9) != 0;
		case ($urandom_range(9))
			7: begin
				return raw[BIN_W-1:0];
			end
			8: begin
				return raw[BIN_W-1:0] >> $urandom_range(53);
			end
			9: begin
				return BIN_W'(raw[BIN_W-1:0] % 64'd10000000000000000);
			end
			default: begin
				case ($urandom_range(7))
					0: begin
						lead = 40 + $urandom_range(9);
						len  = 16;
					end
					1: begin
						lead = 40 + $urandom_range(9);
						len  = 13;
					end
					2: begin
						lead = 51 + $urandom_range(4);
						len  = 16;
					end
					3: begin
						lead = $urandom_range(1) ? 34 : 37;
						len  = 15;
					end
					4: begin
						// leads right next to an issuer window
						case ($urandom_range(5))
							0:       lead = 33;
							1:       lead = 35;
							2:       lead = 38;
							3:       lead = 50;
							4:       lead = 56;
							default: lead = 39;
						endcase
						len = $urandom_range(16, 13);
					end
					5: begin
						lead = $urandom_range(99, 10);
						len  = $urandom_range(16, 12);
					end
					default: begin
						// issuer leads at any length from twelve to sixteen digits
						case ($urandom_range(3))
							0:       lead = 34;
							1:       lead = 37;
							2:       lead = 51 + $urandom_range(4);
							default: lead = 40 + $urandom_range(9);
						endcase
						len = $urandom_range(16, 12);
					end
				endcase
				return build_card(lead, len, make_valid);
			end
		endcase
	endfunction

	// one command transfer; start drops for an idle gap, otherwise it stays
	// high so the next number follows right behind the last one
	task automatic send_card(input logic [BIN_W-1:0] number, input bit typed,
			input card_result_t typed_res, input int unsigned idle_pct);
		int unsigned gap;
		// a gap can be up to a full item long, so it lands on any phase
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(90, 1) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		card_number <= number;
		do begin
			@(posedge clk);
		end while (busy);
		pending_results.push_back(typed ? typed_res : classify_card(number));
	endtask

	task automatic note_failure(input string msg);
		fail_cnt = fail_cnt + 1;
		if (fail_cnt <= 10) begin
			$display("%t: %s", $realtime, msg);
		end
	endtask

	// result transfers: done is high for exactly one cycle per item
	always @(posedge clk) begin
		card_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf({"result with nothing pending:",
					" issuer %0d ok %0d count %0d lead %0d"},
					issuer, checksum_ok, digit_count, leading_pair));
			end else begin
				want = pending_results.pop_front();
				if (issuer !== want.issuer || checksum_ok !== want.checksum_ok ||
						digit_count !== want.digit_count ||
						leading_pair !== want.leading_pair) begin
					note_failure($sformatf({"mismatch: issuer %0d/%0d ok %0d/%0d",
						" count %0d/%0d lead %0d/%0d (expected/actual)"},
						want.issuer, issuer, want.checksum_ok, checksum_ok,
						want.digit_count, digit_count, want.leading_pair, leading_pair));
				end
			end
		end
	end

	initial begin
		// hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED_ROWS[i]) begin
			send_card(DIRECTED_ROWS[i].number, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].res, 16);
		end

		// random numbers: rare gaps, frequent gaps, none at all
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_card(random_card(), 1'b0, NO_RES, 16);
		end
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_card(random_card(), 1'b0, NO_RES, 72);
		end
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			send_card(random_card(), 1'b0, NO_RES, 0);
		end
		start <= 1'b0;

		// drain, then watch a while longer for stray strobes
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		if (fail_cnt == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
